@@ sv/vvf_pkg.sv @@
// ----------------------------------------------------------------------------
// vvf_pkg
// Shared types, constants and table functions of the vortex velocity field.
// ----------------------------------------------------------------------------
package vvf_pkg;

  // grid and number formats
  localparam int unsigned GRID_SIZE = 1024;
  localparam int unsigned R2_W      = 22;   // squared distance in cells
  localparam int unsigned RQ_W      = 27;   // distance in Q16
  localparam int unsigned SQ_REM_W  = 28;   // square root partial remainder
  localparam int unsigned Q_W       = 31;   // Q30 values up to and including 1.0
  localparam int unsigned SIN_STEPS = 5;
  localparam logic [31:0] Q30_ONE   = 32'h4000_0000;
  localparam logic [31:0] PI_Q30    = 32'd3373259426;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_CENTER_X    = 3'd0,
    CFG_CENTER_Y    = 3'd1,
    CFG_RANGE_CELLS = 3'd2,
    CFG_SPEED_GAIN  = 3'd3,
    CFG_DIRECTION   = 3'd4
  } cfg_idx_e;

  // velocity component selection
  typedef enum logic [1:0] {
    DIR_CW_X  = 2'd0,
    DIR_CW_Y  = 2'd1,
    DIR_CCW_X = 2'd2,
    DIR_CCW_Y = 2'd3
  } dir_e;

  // per-transaction control travelling alongside the datapath
  typedef struct packed {
    logic valid;
    logic en;     // velocity is computed, otherwise forced to zero
    logic ins;    // cell inside the vortex range
    logic dneg;   // direction term is negative
  } sb_t;

  // Horner divisors of the sine series, highest order first
  function automatic int unsigned sin_div(input int unsigned k);
    int unsigned d;
    case (k)
      0:       d = 110;
      1:       d = 72;
      2:       d = 42;
      3:       d = 20;
      default: d = 6;
    endcase
    return d;
  endfunction

  // reciprocal shift: 32 plus floor(log2(divisor))
  function automatic int unsigned sin_shift(input int unsigned k);
    int unsigned s;
    case (k)
      0:       s = 38;
      1:       s = 38;
      2:       s = 37;
      3:       s = 36;
      default: s = 34;
    endcase
    return s;
  endfunction

endpackage

@@ sv/vortex_velocity_field.sv @@
// ----------------------------------------------------------------------------
// vortex_velocity_field
// One velocity component of a vortex for each grid cell, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive row_i/col_i with start_i high; busy_o is always low,
//   so a transaction is taken every cycle that start_i is high.
//   Output channel: valid_o strobes for one cycle with velocity_o and
//   inside_res_o; the receiver cannot stall, results must be captured.
//   Throughput is one cell per cycle. The depth is set by the 27-cell square
//   root chain, the two 31-cell division chains running side by side and the
//   five three-stage sine steps.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i;
//   unknown indexes are dropped. Write only while the pipeline is empty.
//   Reset clears all transactions in flight and restores the register defaults
//   (centre 0, range 0, speed 1.0, clockwise x).
// ----------------------------------------------------------------------------
module vortex_velocity_field (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [9:0]         row_i,
  input  logic [9:0]         col_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  output logic               valid_o,
  output logic signed [15:0] velocity_o,
  output logic               inside_res_o
);

  localparam int SQ_IN  = 1;
  localparam int DV_IN  = SQ_IN + vvf_pkg::RQ_W;
  localparam int FO     = DV_IN + vvf_pkg::Q_W;
  localparam int ST_U   = FO + 1;
  localparam int ST_X   = FO + 2;
  localparam int SN_IN  = FO + 3;
  localparam int SN_OUT = SN_IN + 3 * vvf_pkg::SIN_STEPS;
  localparam int ST_S   = SN_OUT + 1;
  localparam int ST_M   = SN_OUT + 2;
  localparam int ST_MAG = SN_OUT + 3;
  localparam int LAT    = SN_OUT + 4;
  localparam int QW     = vvf_pkg::Q_W;
  localparam int RW     = vvf_pkg::RQ_W;

  // configuration registers
  logic [9:0]         center_x_q, center_y_q;
  logic [10:0]        range_q;
  logic signed [15:0] speed_q;
  logic [1:0]         dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      range_q    <= '0;
      speed_q    <= 16'sd256;
      dir_q      <= 2'(vvf_pkg::DIR_CW_X);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vvf_pkg::CFG_CENTER_X:    center_x_q <= cfg_wdata_i[9:0];
        vvf_pkg::CFG_CENTER_Y:    center_y_q <= cfg_wdata_i[9:0];
        vvf_pkg::CFG_RANGE_CELLS: range_q    <= cfg_wdata_i[10:0];
        vvf_pkg::CFG_SPEED_GAIN:  speed_q    <= $signed(cfg_wdata_i);
        vvf_pkg::CFG_DIRECTION:   dir_q      <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // control line alongside the datapath
  logic       v0_q;
  vvf_pkg::sb_t sb_q [SQ_IN:LAT];
  vvf_pkg::sb_t sb1_d;

  // stage 0: offsets from the centre
  logic signed [10:0] dx0_q, dy0_q;
  logic               og0_q;

  always_ff @(posedge clk_i) begin
    dx0_q <= $signed({1'b0, col_i}) - $signed({1'b0, center_x_q});
    dy0_q <= $signed({1'b0, row_i}) - $signed({1'b0, center_y_q});
    og0_q <= (32'(row_i) < vvf_pkg::GRID_SIZE) && (32'(col_i) < vvf_pkg::GRID_SIZE);
  end

  // stage 1: squared distance, range test and direction term
  logic signed [21:0]        sqx, sqy;
  logic [vvf_pkg::R2_W-1:0]  r2;
  logic [21:0]               rng2;
  logic signed [10:0]        dsel;
  logic [9:0]                magd;
  logic [vvf_pkg::R2_W-1:0]  r2_1_q;
  logic [9:0]                magd_q [SQ_IN:DV_IN];

  always_comb begin
    sqx  = dx0_q * dx0_q;
    sqy  = dy0_q * dy0_q;
    r2   = vvf_pkg::R2_W'($unsigned(sqx)) + vvf_pkg::R2_W'($unsigned(sqy));
    rng2 = 22'(range_q) * 22'(range_q);
    case (dir_q)
      vvf_pkg::DIR_CW_X:  dsel = -dx0_q;
      vvf_pkg::DIR_CW_Y:  dsel = dy0_q;
      vvf_pkg::DIR_CCW_X: dsel = -dy0_q;
      default:            dsel = dx0_q;
    endcase
    magd        = dsel[10] ? 10'(-dsel) : dsel[9:0];
    sb1_d.valid = v0_q;
    sb1_d.ins   = og0_q && (r2 <= rng2);
    sb1_d.en    = sb1_d.ins && (r2 != '0) && (range_q != '0);
    sb1_d.dneg  = dsel[10];
  end

  always_ff @(posedge clk_i) begin
    r2_1_q         <= r2;
    magd_q[SQ_IN]  <= magd;
    for (int i = SQ_IN; i < DV_IN; i++) begin
      magd_q[i+1] <= magd_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      for (int i = SQ_IN; i <= LAT; i++) begin
        sb_q[i] <= '0;
      end
    end else begin
      v0_q        <= start_i;
      sb_q[SQ_IN] <= sb1_d;
      for (int i = SQ_IN; i < LAT; i++) begin
        sb_q[i+1] <= sb_q[i];
      end
    end
  end

  // square root chain: distance in Q16
  logic [RW-1:0]                root_c [0:RW];
  logic [vvf_pkg::SQ_REM_W-1:0] srem_c [0:RW];
  logic [vvf_pkg::R2_W-1:0]     rad_c  [0:RW];

  assign root_c[0] = '0;
  assign srem_c[0] = '0;
  assign rad_c[0]  = r2_1_q;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    vvf_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .root_i (root_c[k]),
      .rem_i  (srem_c[k]),
      .rad_i  (rad_c[k]),
      .root_o (root_c[k+1]),
      .rem_o  (srem_c[k+1]),
      .rad_o  (rad_c[k+1])
    );
  end

  logic [RW-1:0] rq;
  assign rq = root_c[RW];

  // phase division: t = r / range in Q30
  logic [10:0]   tden_c [0:QW];
  logic [10:0]   trem_c [0:QW];
  logic [QW-1:0] tnq_c  [0:QW];

  assign tden_c[0] = range_q;
  assign trem_c[0] = {1'b0, rq[RW-1:17]};
  assign tnq_c[0]  = {rq[16:0], 14'd0};

  for (genvar k = 0; k < QW; k++) begin : g_tdiv
    vvf_div_cell #(.DW(11)) u_cell (
      .clk_i (clk_i),
      .den_i (tden_c[k]),
      .rem_i (trem_c[k]),
      .nq_i  (tnq_c[k]),
      .den_o (tden_c[k+1]),
      .rem_o (trem_c[k+1]),
      .nq_o  (tnq_c[k+1])
    );
  end

  // ratio division: |dir| / r in Q30
  logic [RW-1:0] cden_c [0:QW];
  logic [RW-1:0] crem_c [0:QW];
  logic [QW-1:0] cnq_c  [0:QW];

  assign cden_c[0] = rq;
  assign crem_c[0] = RW'({magd_q[DV_IN], 15'd0});
  assign cnq_c[0]  = '0;

  for (genvar k = 0; k < QW; k++) begin : g_cdiv
    vvf_div_cell #(.DW(RW)) u_cell (
      .clk_i (clk_i),
      .den_i (cden_c[k]),
      .rem_i (crem_c[k]),
      .nq_i  (cnq_c[k]),
      .den_o (cden_c[k+1]),
      .rem_o (crem_c[k+1]),
      .nq_o  (cnq_c[k+1])
    );
  end

  // clamp and fold the phase, clamp the ratio
  logic [QW-1:0] one_q30;
  logic [QW-1:0] tcl, tfold, u;
  logic [QW-1:0] u_q;
  logic [QW-1:0] cc_q [ST_U:ST_S];
  logic [62:0]   xprod;
  logic [QW-1:0] x_q  [ST_X:SN_OUT];
  logic [61:0]   x2prod;
  logic [31:0]   x2_q;

  assign one_q30 = QW'(vvf_pkg::Q30_ONE);

  always_comb begin
    tcl    = (tnq_c[QW] > one_q30) ? one_q30 : tnq_c[QW];
    tfold  = one_q30 - tcl;
    u      = (tcl > tfold) ? tfold : tcl;
    xprod  = 63'(u_q) * 63'(vvf_pkg::PI_Q30);
    x2prod = 62'(x_q[ST_X]) * 62'(x_q[ST_X]);
  end

  always_ff @(posedge clk_i) begin
    u_q         <= u;
    cc_q[ST_U]  <= (cnq_c[QW] > one_q30) ? one_q30 : cnq_c[QW];
    for (int i = ST_U; i < ST_S; i++) begin
      cc_q[i+1] <= cc_q[i];
    end
    x_q[ST_X]   <= xprod[60:30];
    for (int i = ST_X; i < SN_OUT; i++) begin
      x_q[i+1] <= x_q[i];
    end
    x2_q        <= x2prod[61:30];
  end

  // sine series, Horner steps from the highest order down
  logic [31:0]   sx2_c [0:vvf_pkg::SIN_STEPS];
  logic [QW-1:0] st_c  [0:vvf_pkg::SIN_STEPS];

  assign sx2_c[0] = x2_q;
  assign st_c[0]  = one_q30;

  for (genvar k = 0; k < vvf_pkg::SIN_STEPS; k++) begin : g_sin
    vvf_sin_step #(.IDX(k)) u_step (
      .clk_i (clk_i),
      .x2_i  (sx2_c[k]),
      .t_i   (st_c[k]),
      .x2_o  (sx2_c[k+1]),
      .t_o   (st_c[k+1])
    );
  end

  // sine, product with the ratio, then with the speed
  logic [61:0]        sprod, mprod;
  logic [QW-1:0]      s_q, m_q;
  logic [15:0]        amag;
  logic [46:0]        gprod;
  logic [16:0]        mag_q;
  logic               neg_q;
  logic signed [15:0] vel_d;

  always_comb begin
    sprod = 62'(x_q[SN_OUT]) * 62'(st_c[vvf_pkg::SIN_STEPS]);
    mprod = 62'(s_q) * 62'(cc_q[ST_S]);
    amag  = speed_q[15] ? 16'(-speed_q) : speed_q;
    gprod = 47'(amag) * 47'(m_q) + 47'(vvf_pkg::Q30_ONE >> 1);
    if (!sb_q[ST_MAG].en) begin
      vel_d = '0;
    end else if (neg_q) begin
      vel_d = (mag_q > 17'd32768) ? 16'sh8000 : 16'(-mag_q);
    end else begin
      vel_d = (mag_q > 17'd32767) ? 16'sh7fff : mag_q[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    s_q        <= QW'(sprod >> 30);
    m_q        <= QW'(mprod >> 30);
    mag_q      <= gprod[46:30];
    neg_q      <= sb_q[ST_M].dneg ^ speed_q[15];
    velocity_o <= vel_d;
  end

  assign valid_o      = sb_q[LAT].valid;
  assign inside_res_o = sb_q[LAT].ins;

`ifndef ASSERT_OFF
  // every accepted cell gives a strobe after the pipeline depth
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##(LAT + 1) valid_o)
    else $error("result strobe missing after pipeline latency");

  // a non-zero velocity only ever comes from a cell inside the range
  a_vel_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (velocity_o != '0) |-> inside_res_o)
    else $error("velocity outside vortex range");

  // an active cell off centre has a distance of at least one cell
  a_sqrt_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sb_q[DV_IN].valid && sb_q[DV_IN].en |-> (rq[RW-1:16] != '0))
    else $error("square root below one cell for an active transaction");

  // the phase quotient of an active cell never exceeds one
  a_phase_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sb_q[FO].valid && sb_q[FO].en |-> (tnq_c[QW] <= one_q30))
    else $error("phase quotient above one");
`endif

endmodule

@@ sv/vvf_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// vvf_sqrt_cell
// One digit step of the integer square root, one result bit per cell.
// ----------------------------------------------------------------------------
module vvf_sqrt_cell (
  input  logic                               clk_i,
  input  logic [vvf_pkg::RQ_W-1:0]           root_i,
  input  logic [vvf_pkg::SQ_REM_W-1:0]       rem_i,
  input  logic [vvf_pkg::R2_W-1:0]           rad_i,
  output logic [vvf_pkg::RQ_W-1:0]           root_o,
  output logic [vvf_pkg::SQ_REM_W-1:0]       rem_o,
  output logic [vvf_pkg::R2_W-1:0]           rad_o
);

  logic [vvf_pkg::SQ_REM_W+1:0] acc;
  logic [vvf_pkg::SQ_REM_W+1:0] trial;
  logic [vvf_pkg::SQ_REM_W+1:0] diff;
  logic                         ge;
  logic [vvf_pkg::RQ_W-1:0]     root_d;
  logic [vvf_pkg::SQ_REM_W-1:0] rem_d;
  logic [vvf_pkg::R2_W-1:0]     rad_d;

  // trial subtract of the next radicand pair
  always_comb begin
    acc    = {rem_i, rad_i[vvf_pkg::R2_W-1 -: 2]};
    trial  = {1'b0, root_i, 2'b01};
    diff   = acc - trial;
    ge     = (acc >= trial);
    root_d = {root_i[vvf_pkg::RQ_W-2:0], ge};
    rem_d  = ge ? diff[vvf_pkg::SQ_REM_W-1:0] : acc[vvf_pkg::SQ_REM_W-1:0];
    rad_d  = {rad_i[vvf_pkg::R2_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    root_o <= root_d;
    rem_o  <= rem_d;
    rad_o  <= rad_d;
  end

endmodule

@@ sv/vvf_div_cell.sv @@
// ----------------------------------------------------------------------------
// vvf_div_cell
// One restoring division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
module vvf_div_cell #(
  parameter int unsigned DW = 11
) (
  input  logic                        clk_i,
  input  logic [DW-1:0]               den_i,
  input  logic [DW-1:0]               rem_i,
  input  logic [vvf_pkg::Q_W-1:0]     nq_i,
  output logic [DW-1:0]               den_o,
  output logic [DW-1:0]               rem_o,
  output logic [vvf_pkg::Q_W-1:0]     nq_o
);

  logic [DW:0]               tr;
  logic [DW:0]               diff;
  logic                      ge;
  logic [DW-1:0]             rem_d;
  logic [vvf_pkg::Q_W-1:0]   nq_d;

  // shift in the next numerator bit, quotient bit shifts in at the bottom
  always_comb begin
    tr    = {rem_i, nq_i[vvf_pkg::Q_W-1]};
    diff  = tr - {1'b0, den_i};
    ge    = (tr >= {1'b0, den_i});
    rem_d = ge ? diff[DW-1:0] : tr[DW-1:0];
    nq_d  = {nq_i[vvf_pkg::Q_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    den_o <= den_i;
    rem_o <= rem_d;
    nq_o  <= nq_d;
  end

endmodule

@@ sv/vvf_sin_step.sv @@
// ----------------------------------------------------------------------------
// vvf_sin_step
// One Horner step of the sine series: t = 1 - (x2 * t) / divisor, three stages.
// ----------------------------------------------------------------------------
module vvf_sin_step #(
  parameter int unsigned IDX = 0
) (
  input  logic                      clk_i,
  input  logic [31:0]               x2_i,
  input  logic [vvf_pkg::Q_W-1:0]   t_i,
  output logic [31:0]               x2_o,
  output logic [vvf_pkg::Q_W-1:0]   t_o
);

  localparam int unsigned D      = vvf_pkg::sin_div(IDX);
  localparam int unsigned K      = vvf_pkg::sin_shift(IDX);
  localparam logic [63:0] M_FULL = (64'd1 << K) / 64'(D);
  localparam logic [31:0] M      = M_FULL[31:0];

  logic [62:0]             prod_q;
  logic [31:0]             x2a_q;
  logic [31:0]             p;
  logic [63:0]             pm_q;
  logic [31:0]             p_q;
  logic [31:0]             x2b_q;
  logic [31:0]             q0;
  logic [31:0]             qd;
  logic [31:0]             r;
  logic [31:0]             q;
  logic [vvf_pkg::Q_W-1:0] t_d;

  assign p = prod_q[61:30];

  // quotient by reciprocal, then one correction step and the subtract from one
  always_comb begin
    q0  = 32'(pm_q >> K);
    qd  = q0 * 32'(D);
    r   = p_q - qd;
    q   = q0 + ((r >= 32'(D)) ? 32'd1 : 32'd0);
    t_d = (q >= vvf_pkg::Q30_ONE) ? '0 : vvf_pkg::Q_W'(vvf_pkg::Q30_ONE - q);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 63'(x2_i) * 63'(t_i);
    x2a_q  <= x2_i;
    pm_q   <= 64'(p) * 64'(M);
    p_q    <= p;
    x2b_q  <= x2a_q;
    t_o    <= t_d;
    x2_o   <= x2b_q;
  end

endmodule

@@ test/tb_vortex_velocity_field.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vortex_velocity_field
// Self-checking bench for the vortex velocity field. A short table of directed
// cells and register settings is followed by random cells, mostly clustered around
// the vortex of each phase; results are compared with a bit-true model or fixed values.
// ----------------------------------------------------------------------------
module tb_vortex_velocity_field;

  localparam logic [2:0] CFG_UNUSED = 3'd7;    // index beyond the register list
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned RAND_PHASES  = 8;
  localparam int unsigned PHASE_CELLS  = 190;

  typedef enum logic { ROW_CELL, ROW_REGS } row_kind_e;

  typedef struct {
    row_kind_e         kind;
    int                a, b, c, d, e;   // cell: row, col; regs: cx, cy, range, gain, dir
    bit                fixed;
    logic signed [15:0] want_vel;
    logic              want_ins;
  } stim_row_t;

  typedef struct {
    logic signed [15:0] vel;
    logic               ins;
  } vel_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [9:0]         row_i = '0;
  logic [9:0]         col_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = vvf_pkg::CFG_CENTER_X;
  logic [15:0]        cfg_wdata_i = '0;
  logic               valid_o;
  logic signed [15:0] velocity_o;
  logic               inside_res_o;

  // shadow copy of the registers
  logic [9:0]         sh_cx, sh_cy;
  logic [10:0]        sh_range;
  logic signed [15:0] sh_gain;
  vvf_pkg::dir_e      sh_dir;

  vel_result_t pending_vel[$];
  stim_row_t   stim_tbl[$];
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles  = 0;

  vortex_velocity_field u_top (.*);

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // integer square root, bit by bit
  function automatic longint unsigned sqrt_floor(input longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt  = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // sine over the first quadrant, Q30 in and out
  function automatic longint unsigned sine_q30(input longint unsigned x);
    longint unsigned x2, t, sub, dv;
    x2 = (x * x) >> 30;
    t  = 64'd1 << 30;
    for (int k = 0; k < 5; k++) begin
      case (k)
        0:       dv = 110;
        1:       dv = 72;
        2:       dv = 42;
        3:       dv = 20;
        default: dv = 6;
      endcase
      sub = ((x2 * t) >> 30) / dv;
      t   = (sub >= (64'd1 << 30)) ? 0 : (64'd1 << 30) - sub;
    end
    return (x * t) >> 30;
  endfunction

  // velocity component of one cell under the shadow registers
  function automatic vel_result_t vortex_velocity(input int row, input int col);
    vel_result_t     res;
    int              dx, dy, dd;
    longint unsigned r2, rng, rq, t, u, x, s, c, m, amag, mag, one;
    bit              neg;
    one = 64'd1 << 30;
    dx  = col - int'(sh_cx);
    dy  = row - int'(sh_cy);
    r2  = longint'(dx) * dx + longint'(dy) * dy;
    rng = sh_range;
    res.vel = '0;
    res.ins = (r2 <= rng * rng);
    if (res.ins && r2 != 0 && rng != 0) begin
      rq = sqrt_floor(r2 << 32);
      t  = (rq << 14) / rng;
      if (t > one) t = one;
      u  = (t > one - t) ? one - t : t;
      x  = (u * 64'd3373259426) >> 30;
      s  = sine_q30(x);
      case (sh_dir)
        vvf_pkg::DIR_CW_X:  dd = -dx;
        vvf_pkg::DIR_CW_Y:  dd = dy;
        vvf_pkg::DIR_CCW_X: dd = -dy;
        default:            dd = dx;
      endcase
      neg = dd < 0;
      c   = (longint'(neg ? -dd : dd) << 46) / rq;
      if (c > one) c = one;
      m = (s * c) >> 30;
      if (sh_gain < 0) begin
        neg  = !neg;
        amag = -longint'(sh_gain);
      end else begin
        amag = longint'(sh_gain);
      end
      mag = (amag * m + (64'd1 << 29)) >> 30;
      if (neg) res.vel = (mag > 32768) ? -16'sd32768 : 16'(-longint'(mag));
      else     res.vel = (mag > 32767) ? 16'sd32767 : 16'(mag);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatch_cnt++;
  endtask

  // wait until every expected transaction has come back
  task automatic wait_drained();
    while (pending_vel.size() != 0) @(posedge clk_i);
  endtask

  // write all registers back to back, preceded by a write to an unused index
  task automatic program_regs(input int cx, input int cy, input int rng, input int gain,
                              input int dir);
    logic [15:0] vals[6];
    logic [2:0]  idxs[6];
    wait_drained();
    idxs = '{CFG_UNUSED, vvf_pkg::CFG_CENTER_X, vvf_pkg::CFG_CENTER_Y,
             vvf_pkg::CFG_RANGE_CELLS, vvf_pkg::CFG_SPEED_GAIN, vvf_pkg::CFG_DIRECTION};
    vals = '{16'hFFFF, 16'(cx), 16'(cy), 16'(rng), 16'(gain), 16'(dir)};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idxs[i];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    sh_cx    = 10'(cx);
    sh_cy    = 10'(cy);
    sh_range = 11'(rng);
    sh_gain  = 16'(gain);
    sh_dir   = vvf_pkg::dir_e'(dir[1:0]);
  endtask

  // offer one cell; returns at the accepting edge with start still high
  task automatic send_cell(input int row, input int col, input bit fixed,
                           input vel_result_t want);
    bit bsy;
    start_i <= 1'b1;
    row_i   <= 10'(row);
    col_i   <= 10'(col);
    do begin
      @(negedge clk_i);
      bsy = busy_o;
      @(posedge clk_i);
    end while (bsy);
    pending_vel.push_back(fixed ? want : vortex_velocity(row, col));
  endtask

  task automatic idle_gap(input int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic stim_row_t cell_row(input int row, input int col, input bit fixed = 0,
                                         input int vel = 0, input bit ins = 0);
    stim_row_t r;
    r = '{ROW_CELL, row, col, 0, 0, 0, fixed, 16'(vel), ins};
    return r;
  endfunction

  function automatic stim_row_t regs_row(input int cx, input int cy, input int rng,
                                         input int gain, input vvf_pkg::dir_e dir);
    stim_row_t r;
    r = '{ROW_REGS, cx, cy, rng, gain, int'(dir), 0, '0, 1'b0};
    return r;
  endfunction

  // result checker, sampled mid-cycle
  always @(negedge clk_i) begin
    vel_result_t want;
    if (valid_o) begin
      if (pending_vel.size() == 0) begin
        report_mismatch("unexpected result, velocity", velocity_o, 0);
      end else begin
        want = pending_vel.pop_front();
        if (velocity_o !== want.vel) report_mismatch("velocity", velocity_o, want.vel);
        if (inside_res_o !== want.ins) report_mismatch("inside", inside_res_o, want.ins);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(negedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired at %0t", $realtime);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    vel_result_t want;
    stim_row_t   sr;
    int burst_left, cx, cy, rng, gain, dir, lim, row, col;

    sh_cx = 0; sh_cy = 0; sh_range = 0; sh_gain = 16'sd256; sh_dir = vvf_pkg::DIR_CW_X;

    // directed table: reset state, edges of the range, each direction, extremes
    stim_tbl.push_back(cell_row(0, 0, 1, 0, 1));         // centre at reset
    stim_tbl.push_back(cell_row(5, 3, 1, 0, 0));         // zero range, off centre
    stim_tbl.push_back(cell_row(1023, 1023, 1, 0, 0));
    stim_tbl.push_back(regs_row(512, 512, 100, 256, vvf_pkg::DIR_CW_X));
    stim_tbl.push_back(cell_row(512, 512, 1, 0, 1));     // centre cell
    stim_tbl.push_back(cell_row(512, 612, 1, 0, 1));     // on the rim, sine is zero
    stim_tbl.push_back(cell_row(512, 613, 1, 0, 0));     // just outside
    stim_tbl.push_back(cell_row(512, 562));
    stim_tbl.push_back(cell_row(540, 470));
    stim_tbl.push_back(regs_row(512, 512, 100, 256, vvf_pkg::DIR_CW_Y));
    stim_tbl.push_back(cell_row(562, 512));
    stim_tbl.push_back(cell_row(470, 540));
    stim_tbl.push_back(regs_row(512, 512, 100, -700, vvf_pkg::DIR_CCW_X));
    stim_tbl.push_back(cell_row(562, 530));
    stim_tbl.push_back(regs_row(512, 512, 100, 9000, vvf_pkg::DIR_CCW_Y));
    stim_tbl.push_back(cell_row(500, 460));
    // saturation with the most negative gain
    stim_tbl.push_back(regs_row(1, 1, 2, -32768, vvf_pkg::DIR_CW_X));
    stim_tbl.push_back(cell_row(1, 2));
    stim_tbl.push_back(cell_row(1, 0));
    // largest range and gain, centre in both corners
    stim_tbl.push_back(regs_row(0, 0, 2047, 32767, vvf_pkg::DIR_CCW_Y));
    stim_tbl.push_back(cell_row(1023, 1023));
    stim_tbl.push_back(cell_row(0, 700));
    stim_tbl.push_back(regs_row(1023, 1023, 2047, 32767, vvf_pkg::DIR_CW_X));
    stim_tbl.push_back(cell_row(0, 0));
    stim_tbl.push_back(cell_row(1023, 1022));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_tbl[i]) begin
      sr = stim_tbl[i];
      if (sr.kind == ROW_REGS) begin
        start_i <= 1'b0;
        program_regs(sr.a, sr.b, sr.c, sr.d, sr.e);
      end else begin
        want.vel = sr.want_vel;
        want.ins = sr.want_ins;
        send_cell(sr.a, sr.b, sr.fixed, want);
        if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 4));
      end
    end

    // random phases, each with its own vortex
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) begin
        cx = 0; cy = 1023; rng = 2047; gain = 32767;
      end else if (ph == RAND_PHASES - 1) begin
        cx = 1023; cy = 0; rng = 1; gain = -32768;
      end else begin
        cx   = $urandom_range(0, 1023);
        cy   = $urandom_range(0, 1023);
        rng  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 64);
        gain = $urandom_range(0, 65535) - 32768;
      end
      dir = (ph + $urandom_range(0, 1)) % 4;
      start_i <= 1'b0;
      program_regs(cx, cy, rng, gain, dir);
      lim = (rng + 1 > 1023) ? 1023 : rng + 1;
      burst_left = $urandom_range(1, 40);
      for (int n = 0; n < PHASE_CELLS; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          row = $urandom_range(0, 1023);
          col = $urandom_range(0, 1023);
        end else begin
          row = cy + $urandom_range(0, 2 * lim) - lim;
          col = cx + $urandom_range(0, 2 * lim) - lim;
          row = (row < 0) ? 0 : (row > 1023) ? 1023 : row;
          col = (col < 0) ? 0 : (col > 1023) ? 1023 : col;
        end
        send_cell(row, col, 0, want);
        if (--burst_left == 0) begin
          // pause for a full drain in the later half of phase 2
          if (ph == 2 && n > PHASE_CELLS / 2) begin
            start_i <= 1'b0;
            wait_drained();
          end else begin
            idle_gap($urandom_range(1, 12));
          end
          burst_left = $urandom_range(1, 40);
        end
      end
    end
    start_i <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
